### rtl/dbc_pkg.sv
// Shared widths, register indexes and codes of the density clustering block.
`default_nettype none
package dbc_pkg;
  localparam int FEAT_W     = 16;
  localparam int IDX_W      = 6;
  localparam int CID_W      = 7;
  localparam int EPS_W      = 34;
  localparam int MINN_W     = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 34;
  localparam int POINT_W    = 3 * FEAT_W;

  localparam logic [CFG_IDX_W-1:0] REG_EPS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MINN = 1'd1;

  localparam logic [EPS_W-1:0]  EPS_RESET  = 34'd100;
  localparam logic [MINN_W-1:0] MINN_RESET = 7'd10;

  // Label code for a point found to be noise; zero means unvisited.
  localparam logic [CID_W-1:0] LABEL_NOISE     = 7'd127;
  localparam logic [CID_W-1:0] LABEL_UNVISITED = 7'd0;
endpackage
`default_nettype wire

### rtl/dbc_if.sv
// Handshake channels for points going in and labels coming out.
`default_nettype none
interface dbc_point_if;
  logic                      valid;
  logic                      ready;
  logic [dbc_pkg::FEAT_W-1:0] feature_a;
  logic [dbc_pkg::FEAT_W-1:0] feature_b;
  logic [dbc_pkg::FEAT_W-1:0] feature_c;
  logic                      last_point;
  modport source (output valid, feature_a, feature_b, feature_c, last_point, input ready);
  modport sink   (input valid, feature_a, feature_b, feature_c, last_point, output ready);
endinterface

interface dbc_label_if;
  logic                      valid;
  logic                      ready;
  logic [dbc_pkg::IDX_W-1:0] label_idx;
  logic [dbc_pkg::CID_W-1:0] cluster_id;
  logic                      last_label;
  modport source (output valid, label_idx, cluster_id, last_label, input ready);
  modport sink   (input valid, label_idx, cluster_id, last_label, output ready);
endinterface
`default_nettype wire

### rtl/dbc_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module dbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### rtl/dbc_dist.sv
// Two-stage squared distance unit: squares in the first stage, sum and compare in the second.
`default_nettype none
module dbc_dist #(
  parameter int TAG_W = 6
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  input  wire logic [TAG_W-1:0]            tag_i,
  input  wire logic [dbc_pkg::POINT_W-1:0] pa_i,
  input  wire logic [dbc_pkg::POINT_W-1:0] pb_i,
  input  wire logic [dbc_pkg::EPS_W-1:0]   eps_i,
  output logic                             valid_o,
  output logic                             near_o,
  output logic      [TAG_W-1:0]            tag_o,
  output logic                             busy_o
);
  localparam int FW = dbc_pkg::FEAT_W;

  logic [FW-1:0]     diff [3];
  logic [2*FW-1:0]   sq_q [3];
  logic              sq_vld_q;
  logic [TAG_W-1:0]  sq_tag_q;
  logic [dbc_pkg::EPS_W-1:0] dist_sum;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = (pa_i[k*FW +: FW] >= pb_i[k*FW +: FW])
              ? pa_i[k*FW +: FW] - pb_i[k*FW +: FW]
              : pb_i[k*FW +: FW] - pa_i[k*FW +: FW];
    end
    dist_sum = dbc_pkg::EPS_W'(sq_q[0]) + dbc_pkg::EPS_W'(sq_q[1])
             + dbc_pkg::EPS_W'(sq_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q <= 1'b0;
      valid_o  <= 1'b0;
    end else begin
      sq_vld_q <= valid_i;
      valid_o  <= sq_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      sq_q[k] <= (2*FW)'(diff[k]) * (2*FW)'(diff[k]);
    end
    sq_tag_q <= tag_i;
    tag_o    <= sq_tag_q;
    near_o   <= (dist_sum <= eps_i);
  end

  assign busy_o = sq_vld_q | valid_o;
endmodule
`default_nettype wire

### rtl/dbscan_clustering_top.sv
// Top level of the density clustering block: point loading, cluster search and label output.
//
// Points enter on in_i, one item per accepted handshake, and are stored in load
// order (up to POINTS; further points are dropped). The item whose last_point is
// set starts the search; while it runs in_i.ready is low. Neighbour counting and
// neighbour queueing each sweep the feature memory once over all N stored points,
// one point a cycle through a pipeline of memory read, squares, and sum and compare,
// plus scan and queue steps for each point; how many sweeps a run takes depends on
// how many points are core points. The sweep through the feature memory sets the pace.
// Labels leave on out_o in index order, one item per point, the final one flagged
// by last_label; cluster 0 means noise. Each label passes through a read state and a
// capture state; a stall simply holds the output register and the label walk waits.
// Loading of the next set starts as soon as the final label sits in the output
// register. Reset returns the block to loading with an empty set and restores
// eps_squared to 100 and min_neighbors to 10; no memory clearing pass is needed,
// since labels carry one valid bit per point, cleared at the start of each run.
// Configuration writes on cfg_*_i take effect at the next edge; the user must make
// them only while the block is idle, which the block itself does not enforce.
`default_nettype none
module dbscan_clustering_top #(
  parameter int POINTS = 64
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [dbc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [dbc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  dbc_point_if.sink                             in_i,
  dbc_label_if.source                           out_o
);
  localparam int IW = $clog2(POINTS);
  localparam int CW = $clog2(POINTS + 1);
  localparam logic [CW-1:0] NPTS = CW'(POINTS);

  typedef enum logic [3:0] {
    S_LOAD, S_SCAN_RD, S_SCAN_CHK, S_SWEEP, S_Q_RD, S_Q_WAIT, S_Q_CHK, S_OUT_RD, S_OUT_CAP
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [dbc_pkg::EPS_W-1:0]  eps_q;
  logic [dbc_pkg::MINN_W-1:0] minn_q;

  // Run control.
  logic [CW-1:0] loaded_q, n_q, scan_q, j_q, cnt_q, head_q, tail_q, out_idx_q;
  logic [dbc_pkg::CID_W-1:0] cluster_q;
  logic [IW-1:0] p_q;
  logic [dbc_pkg::POINT_W-1:0] pf_q;
  logic          sweep_queue_q;   // sweep mode: queue neighbours instead of counting
  logic          ctx_expand_q;    // counting sweep belongs to a queued point
  logic          v0_q;
  logic [IW-1:0] tag0_q;
  logic          lab_vld_q [POINTS];
  logic          mark_q [POINTS];
  logic [IW-1:0] lab_raddr_q;

  // Output register.
  logic                      out_vld_q, out_last_q;
  logic [dbc_pkg::IDX_W-1:0] out_pidx_q;
  logic [dbc_pkg::CID_W-1:0] out_cid_q;

  // Memory ports.
  logic                        f_we, l_we, q_we;
  logic [IW-1:0]               f_raddr, l_raddr, l_waddr;
  logic [dbc_pkg::POINT_W-1:0] f_rdata;
  logic [dbc_pkg::CID_W-1:0]   l_wdata, l_rdata, lab_cur;
  logic [IW-1:0]               q_rdata;

  // Distance unit.
  logic          near_vld, near;
  logic [IW-1:0] near_tag;
  logic          dist_busy;

  logic in_acc, issue, sweep_done, core, hit;

  assign in_acc     = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_LOAD);
  assign issue      = (state_q == S_SWEEP) && (j_q != n_q);
  assign sweep_done = (state_q == S_SWEEP) && (j_q == n_q) && !v0_q && !dist_busy;
  assign core       = 8'(cnt_q) >= 8'(minn_q);
  assign hit        = near_vld && near && (near_tag != p_q);
  assign lab_cur    = lab_vld_q[lab_raddr_q] ? l_rdata : dbc_pkg::LABEL_UNVISITED;

  assign out_o.valid      = out_vld_q;
  assign out_o.label_idx  = out_pidx_q;
  assign out_o.cluster_id = out_cid_q;
  assign out_o.last_label = out_last_q;

  // Memory address and write control follows the sequencer state.
  always_comb begin
    f_we    = in_acc && (loaded_q < NPTS);
    f_raddr = j_q[IW-1:0];
    l_raddr = scan_q[IW-1:0];
    l_we    = 1'b0;
    l_waddr = p_q;
    l_wdata = cluster_q;
    q_we    = sweep_queue_q && hit && !mark_q[near_tag] && (state_q == S_SWEEP);
    unique case (state_q)
      S_SCAN_RD: f_raddr = scan_q[IW-1:0];
      S_Q_WAIT: begin
        f_raddr = q_rdata;
        l_raddr = q_rdata;
      end
      S_OUT_RD:  l_raddr = out_idx_q[IW-1:0];
      S_SWEEP: begin
        if (sweep_done && !sweep_queue_q && !ctx_expand_q) begin
          l_we    = 1'b1;
          l_wdata = core ? cluster_q + 1'b1 : dbc_pkg::LABEL_NOISE;
        end
      end
      S_Q_CHK: begin
        l_we = (lab_cur == dbc_pkg::LABEL_NOISE) || (lab_cur == dbc_pkg::LABEL_UNVISITED);
      end
      default: ;
    endcase
  end

  dbc_ram #(.WIDTH(dbc_pkg::POINT_W), .DEPTH(POINTS)) u_feat_ram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (loaded_q[IW-1:0]),
    .wdata_i ({in_i.feature_c, in_i.feature_b, in_i.feature_a}),
    .raddr_i (f_raddr),
    .rdata_o (f_rdata)
  );

  dbc_ram #(.WIDTH(dbc_pkg::CID_W), .DEPTH(POINTS)) u_label_ram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr),
    .wdata_i (l_wdata),
    .raddr_i (l_raddr),
    .rdata_o (l_rdata)
  );

  dbc_ram #(.WIDTH(IW), .DEPTH(POINTS)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (tail_q[IW-1:0]),
    .wdata_i (near_tag),
    .raddr_i (head_q[IW-1:0]),
    .rdata_o (q_rdata)
  );

  dbc_dist #(.TAG_W(IW)) u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v0_q),
    .tag_i   (tag0_q),
    .pa_i    (pf_q),
    .pb_i    (f_rdata),
    .eps_i   (eps_q),
    .valid_o (near_vld),
    .near_o  (near),
    .tag_o   (near_tag),
    .busy_o  (dist_busy)
  );

  // Sequencer with state, configuration registers, counters, marks, valid bits and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_LOAD;
      eps_q         <= dbc_pkg::EPS_RESET;
      minn_q        <= dbc_pkg::MINN_RESET;
      loaded_q      <= '0;
      n_q           <= '0;
      scan_q        <= '0;
      j_q           <= '0;
      cnt_q         <= '0;
      head_q        <= '0;
      tail_q        <= '0;
      out_idx_q     <= '0;
      cluster_q     <= '0;
      p_q           <= '0;
      pf_q          <= '0;
      sweep_queue_q <= 1'b0;
      ctx_expand_q  <= 1'b0;
      v0_q          <= 1'b0;
      tag0_q        <= '0;
      lab_raddr_q   <= '0;
      out_vld_q     <= 1'b0;
      out_last_q    <= 1'b0;
      out_pidx_q    <= '0;
      out_cid_q     <= '0;
      for (int k = 0; k < POINTS; k++) begin
        lab_vld_q[k] <= 1'b0;
        mark_q[k]    <= 1'b0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          dbc_pkg::REG_EPS:  eps_q  <= cfg_data_i[dbc_pkg::EPS_W-1:0];
          dbc_pkg::REG_MINN: minn_q <= cfg_data_i[dbc_pkg::MINN_W-1:0];
          default: ;
        endcase
      end
      if (out_vld_q && out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (l_we) begin
        lab_vld_q[l_waddr] <= 1'b1;
      end
      lab_raddr_q <= l_raddr;
      v0_q        <= issue;
      tag0_q      <= j_q[IW-1:0];

      unique case (state_q)
        S_LOAD: begin
          if (in_acc) begin
            if (in_i.last_point) begin
              n_q       <= (loaded_q < NPTS) ? loaded_q + 1'b1 : loaded_q;
              loaded_q  <= '0;
              scan_q    <= '0;
              head_q    <= '0;
              tail_q    <= '0;
              cluster_q <= '0;
              for (int k = 0; k < POINTS; k++) begin
                lab_vld_q[k] <= 1'b0;
                mark_q[k]    <= 1'b0;
              end
              state_q <= S_SCAN_RD;
            end else if (loaded_q < NPTS) begin
              loaded_q <= loaded_q + 1'b1;
            end
          end
        end
        S_SCAN_RD: begin
          if (scan_q == n_q) begin
            out_idx_q <= '0;
            state_q   <= S_OUT_RD;
          end else begin
            state_q <= S_SCAN_CHK;
          end
        end
        S_SCAN_CHK: begin
          if (lab_cur != dbc_pkg::LABEL_UNVISITED) begin
            scan_q  <= scan_q + 1'b1;
            state_q <= S_SCAN_RD;
          end else begin
            p_q           <= scan_q[IW-1:0];
            pf_q          <= f_rdata;
            j_q           <= '0;
            cnt_q         <= '0;
            sweep_queue_q <= 1'b0;
            ctx_expand_q  <= 1'b0;
            state_q       <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          if (issue) begin
            j_q <= j_q + 1'b1;
          end
          if (hit && !sweep_queue_q) begin
            cnt_q <= cnt_q + 1'b1;
          end
          if (q_we) begin
            mark_q[near_tag] <= 1'b1;
            tail_q           <= tail_q + 1'b1;
          end
          if (sweep_done) begin
            j_q <= '0;
            if (sweep_queue_q) begin
              state_q <= S_Q_RD;
            end else if (!ctx_expand_q) begin
              if (!core) begin
                scan_q  <= scan_q + 1'b1;
                state_q <= S_SCAN_RD;
              end else begin
                cluster_q     <= cluster_q + 1'b1;
                mark_q[p_q]   <= 1'b1;
                sweep_queue_q <= 1'b1;
              end
            end else if (core) begin
              sweep_queue_q <= 1'b1;
            end else begin
              state_q <= S_Q_RD;
            end
          end
        end
        S_Q_RD: begin
          if (head_q < tail_q) begin
            head_q  <= head_q + 1'b1;
            state_q <= S_Q_WAIT;
          end else begin
            scan_q  <= scan_q + 1'b1;
            state_q <= S_SCAN_RD;
          end
        end
        S_Q_WAIT: begin
          p_q     <= q_rdata;
          state_q <= S_Q_CHK;
        end
        S_Q_CHK: begin
          if (lab_cur == dbc_pkg::LABEL_UNVISITED) begin
            pf_q          <= f_rdata;
            j_q           <= '0;
            cnt_q         <= '0;
            sweep_queue_q <= 1'b0;
            ctx_expand_q  <= 1'b1;
            state_q       <= S_SWEEP;
          end else begin
            state_q <= S_Q_RD;
          end
        end
        S_OUT_RD: begin
          if (!out_vld_q || out_o.ready) begin
            state_q <= S_OUT_CAP;
          end
        end
        S_OUT_CAP: begin
          out_vld_q  <= 1'b1;
          out_pidx_q <= dbc_pkg::IDX_W'(out_idx_q);
          out_cid_q  <= (lab_cur == dbc_pkg::LABEL_NOISE) ? dbc_pkg::LABEL_UNVISITED : lab_cur;
          out_last_q <= (out_idx_q + 1'b1 == n_q);
          out_idx_q  <= out_idx_q + 1'b1;
          state_q    <= (out_idx_q + 1'b1 == n_q) ? S_LOAD : S_OUT_RD;
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

`ifndef SYNTHESIS
  // The queue read pointer never passes the write pointer.
  assert property (@(posedge clk_i) disable iff (!rst_ni) head_q <= tail_q)
    else $error("queue head passed tail");
  // Each point is queued at most once, so the queue never holds more than the set.
  assert property (@(posedge clk_i) disable iff (!rst_ni) tail_q <= NPTS)
    else $error("queue overflow");
  // A label that waits on a stalled receiver stays offered and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_vld_q && !out_o.ready) |=>
                   (out_vld_q && $stable({out_pidx_q, out_cid_q, out_last_q})))
    else $error("waiting label changed");
`endif
endmodule
`default_nettype wire

### bench/testbench.sv
// Self-checking testbench for the density clustering block.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  localparam int NPTS = 64;
  localparam longint CYCLE_LIMIT = 3_000_000;

  typedef struct packed {
    logic [dbc_pkg::FEAT_W-1:0] fa;
    logic [dbc_pkg::FEAT_W-1:0] fb;
    logic [dbc_pkg::FEAT_W-1:0] fc;
    logic                       last;
  } point_t;

  typedef struct packed {
    logic [dbc_pkg::IDX_W-1:0] idx;
    logic [dbc_pkg::CID_W-1:0] cid;
    logic                      last;
  } label_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [dbc_pkg::CFG_IDX_W-1:0] cfg_idx_i = dbc_pkg::REG_EPS;
  logic [dbc_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  dbc_point_if pin ();
  dbc_label_if lout ();

  dbscan_clustering_top #(.POINTS(NPTS)) u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_i(pin.sink), .out_o(lout.source)
  );

  always #6 clk_i = ~clk_i;

  // Items waiting to be driven and labels awaiting the block.
  point_t pending_points[$];
  label_t expected_labels[$];

  // Predictor state: its own copy of the point set and registers.
  logic [dbc_pkg::EPS_W-1:0]  eps_sq = dbc_pkg::EPS_RESET;
  logic [dbc_pkg::MINN_W-1:0] min_nb = dbc_pkg::MINN_RESET;
  logic [dbc_pkg::FEAT_W-1:0] pts [NPTS][3];
  int                         npts = 0;

  int  mismatches = 0;
  bit  failed = 0;
  longint cycles = 0;

  // Handshakes seen at the rising edge, consumed by the driver and the sink.
  bit in_taken = 0;
  bit out_taken = 0;

  function automatic bit near(int p, int q);
    logic [dbc_pkg::EPS_W-1:0] sum;
    logic [dbc_pkg::FEAT_W-1:0] d;
    sum = '0;
    for (int k = 0; k < 3; k++) begin
      d = (pts[p][k] > pts[q][k]) ? pts[p][k] - pts[q][k] : pts[q][k] - pts[p][k];
      sum += dbc_pkg::EPS_W'(d) * dbc_pkg::EPS_W'(d);
    end
    return sum <= eps_sq;
  endfunction

  function automatic bit is_core(int p);
    int n;
    n = 0;
    for (int j = 0; j < npts; j++)
      if (j != p && near(p, j)) n++;
    return n >= min_nb;
  endfunction

  // Runs the clustering over the stored set and queues the labels it yields.
  function automatic void cluster_points();
    logic [dbc_pkg::CID_W-1:0] lab [NPTS];
    bit               marked [NPTS];
    int               fifo [$];
    int               cur, n;
    label_t           l;
    cur = 0;
    for (int i = 0; i < NPTS; i++) begin
      lab[i] = dbc_pkg::LABEL_UNVISITED;
      marked[i] = 0;
    end
    for (int i = 0; i < npts; i++) begin
      if (lab[i] != dbc_pkg::LABEL_UNVISITED) continue;
      if (!is_core(i)) begin
        lab[i] = dbc_pkg::LABEL_NOISE;
        continue;
      end
      cur++;
      lab[i] = dbc_pkg::CID_W'(cur);
      marked[i] = 1;
      for (int j = 0; j < npts; j++)
        if (j != i && !marked[j] && near(i, j)) begin
          marked[j] = 1;
          fifo.insert(fifo.size(), j);
        end
      while (fifo.size() > 0) begin
        n = fifo.pop_front();
        if (lab[n] == dbc_pkg::LABEL_NOISE) lab[n] = dbc_pkg::CID_W'(cur);
        else if (lab[n] == dbc_pkg::LABEL_UNVISITED) begin
          lab[n] = dbc_pkg::CID_W'(cur);
          if (is_core(n))
            for (int j = 0; j < npts; j++)
              if (j != n && !marked[j] && near(n, j)) begin
                marked[j] = 1;
                fifo.insert(fifo.size(), j);
              end
        end
      end
    end
    for (int i = 0; i < npts; i++) begin
      l.idx = dbc_pkg::IDX_W'(i);
      l.cid = (lab[i] == dbc_pkg::LABEL_NOISE) ? dbc_pkg::LABEL_UNVISITED : lab[i];
      l.last = (i == npts - 1);
      expected_labels.insert(expected_labels.size(), l);
    end
    npts = 0;
  endfunction

  function automatic void predict_point(point_t p);
    if (npts < NPTS) begin
      pts[npts][0] = p.fa;
      pts[npts][1] = p.fb;
      pts[npts][2] = p.fc;
      npts++;
    end
    if (p.last) cluster_points();
  endfunction

  // Adds one item to the end of the pending queue.
  function automatic void add_point(logic [15:0] fa, logic [15:0] fb, logic [15:0] fc,
                                    logic last);
    point_t p;
    p.fa = fa;
    p.fb = fb;
    p.fc = fc;
    p.last = last;
    pending_points.insert(pending_points.size(), p);
  endfunction

  // Driver: one item at a time, with a random gap drawn after each.
  int gap_left = 0;
  bit drv_busy = 0;
  initial begin
    pin.valid = 1'b0;
    pin.feature_a = '0;
    pin.feature_b = '0;
    pin.feature_c = '0;
    pin.last_point = 1'b0;
  end
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        drv_busy = 0;
        in_taken = 0;
      end
      if (!drv_busy) begin
        if (gap_left > 0) begin
          gap_left--;
          pin.valid <= 1'b0;
        end else if (pending_points.size() > 0) begin
          point_t p;
          p = pending_points.pop_front();
          pin.valid <= 1'b1;
          pin.feature_a <= p.fa;
          pin.feature_b <= p.fb;
          pin.feature_c <= p.fc;
          pin.last_point <= p.last;
          drv_busy = 1;
          gap_left = $urandom_range(0, 11);
          if ($urandom_range(0, 3) == 0) gap_left = 0;
        end else begin
          pin.valid <= 1'b0;
        end
      end
    end
  end

  // Sink stall: ready is dropped for a drawn number of cycles per label.
  int stall_left = 0;
  initial lout.ready = 1'b0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) begin
        out_taken = 0;
        stall_left = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0) stall_left = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        lout.ready <= 1'b0;
      end else begin
        lout.ready <= 1'b1;
      end
    end
  end

  // Monitor: the point is predicted when accepted, the label checked likewise.
  always @(posedge clk_i) begin
    point_t ip;
    cycles++;
    if (rst_ni && pin.valid && pin.ready) begin
      in_taken = 1;
      ip.fa = pin.feature_a;
      ip.fb = pin.feature_b;
      ip.fc = pin.feature_c;
      ip.last = pin.last_point;
      predict_point(ip);
    end
    if (rst_ni && lout.valid && lout.ready) begin
      out_taken = 1;
      if (expected_labels.size() == 0) begin
        failed = 1;
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected label: index %0d cluster %0d", lout.label_idx,
                   lout.cluster_id);
      end else begin
        label_t e;
        e = expected_labels.pop_front();
        if (e.idx !== lout.label_idx || e.cid !== lout.cluster_id ||
            e.last !== lout.last_label) begin
          failed = 1;
          mismatches++;
          if (mismatches <= 10)
            $display("label mismatch: expected idx %0d cid %0d last %0b, got %0d %0d %0b",
                     e.idx, e.cid, e.last, lout.label_idx, lout.cluster_id,
                     lout.last_label);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Registers are only written when everything has drained.
  task automatic write_reg(logic [dbc_pkg::CFG_IDX_W-1:0] idx,
                           logic [dbc_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == dbc_pkg::REG_EPS) eps_sq = val[dbc_pkg::EPS_W-1:0];
    else min_nb = val[dbc_pkg::MINN_W-1:0];
  endtask

  task automatic drain();
    wait (pending_points.size() == 0 && !drv_busy && expected_labels.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  // A cluster set: points scattered around four centres with spread 'spr', some random outliers; all random if 'wide'.
  task automatic queue_set(int count, int spr, bit wide);
    point_t p;
    int cx[4], cy[4], cz[4], c;
    for (int k = 0; k < 4; k++) begin
      cx[k] = $urandom_range(spr, 65535 - spr);
      cy[k] = $urandom_range(spr, 65535 - spr);
      cz[k] = $urandom_range(spr, 65535 - spr);
    end
    for (int i = 0; i < count; i++) begin
      if (wide || $urandom_range(0, 7) == 0) begin
        p.fa = 16'($urandom); p.fb = 16'($urandom); p.fc = 16'($urandom);
      end else begin
        c = $urandom_range(0, 3);
        p.fa = 16'(cx[c] + int'($urandom_range(0, 2 * spr)) - spr);
        p.fb = 16'(cy[c] + int'($urandom_range(0, 2 * spr)) - spr);
        p.fc = 16'(cz[c] + int'($urandom_range(0, 2 * spr)) - spr);
      end
      p.last = (i == count - 1);
      pending_points.insert(pending_points.size(), p);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes of the fields, a single point, defaults.
    add_point(16'h0000, 16'h0000, 16'h0000, 1'b0);
    add_point(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    add_point(16'h0000, 16'hFFFF, 16'h5555, 1'b0);
    add_point(16'hFFFF, 16'h0000, 16'hAAAA, 1'b1);
    add_point(16'h1234, 16'h1234, 16'h1234, 1'b1);
    drain();

    // Threshold zero and a radius covering every distance: one big cluster.
    write_reg(dbc_pkg::REG_MINN, '0);
    write_reg(dbc_pkg::REG_EPS, 34'h3FFFFFFFF);
    add_point(16'h0000, 16'h0000, 16'h0000, 1'b0);
    add_point(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    add_point(16'h8000, 16'h0001, 16'hFFFE, 1'b1);
    drain();

    // Zero radius with duplicates; threshold above the set size makes all noise.
    write_reg(dbc_pkg::REG_EPS, '0);
    write_reg(dbc_pkg::REG_MINN, 34'd1);
    for (int i = 0; i < 4; i++)
      add_point(16'h0042, 16'h0042, 16'h0042, 1'(i == 3));
    drain();
    write_reg(dbc_pkg::REG_MINN, 34'd127);
    queue_set(5, 20, 0);
    drain();

    // Store full: 66 points, the two extra ones dropped, last still runs.
    write_reg(dbc_pkg::REG_MINN, 34'd3);
    write_reg(dbc_pkg::REG_EPS, 34'd4000);
    queue_set(66, 40, 0);
    drain();

    // Random sets under several settings.
    for (int s = 0; s < 10; s++) begin
      write_reg(dbc_pkg::REG_EPS,
                (s % 5 == 0) ? 34'($urandom) : 34'($urandom_range(50, 20000)));
      write_reg(dbc_pkg::REG_MINN,
                (s % 7 == 3) ? 34'd64 : 34'($urandom_range(0, 6)));
      queue_set((s == 6) ? 20 : $urandom_range(2, 14), $urandom_range(5, 60), s % 6 == 5);
      drain();
    end

    // Back to defaults for a last set.
    write_reg(dbc_pkg::REG_EPS, 34'(dbc_pkg::EPS_RESET));
    write_reg(dbc_pkg::REG_MINN, 34'(dbc_pkg::MINN_RESET));
    queue_set(12, 4, 0);
    drain();
    repeat (50) @(posedge clk_i);

    if (!failed && expected_labels.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

### dbscan_clustering_top.f
rtl/dbc_pkg.sv
rtl/dbc_if.sv
rtl/dbc_ram.sv
rtl/dbc_dist.sv
rtl/dbscan_clustering_top.sv
bench/testbench.sv
